FILE: src/sps_pkg.sv
// ----------------------------------------------------------------------------
// Sandpile sweep package
// Shared types and constants for the sandpile toppling sweep block.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SWEEP_RD,
        ST_SWEEP_CHK,
        ST_SWEEP_NB,
        ST_SWEEP_DONE
    } sps_state_t;

    // Operation codes carried in s_tuser.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } sps_op_t;

    // Neighbor codes, also the bit positions in the neighbor mask.
    localparam logic [1:0] NB_RIGHT = 2'd0;
    localparam logic [1:0] NB_LEFT  = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    // Grain arithmetic constants.
    localparam logic [15:0] GRAIN_MAX     = 16'hFFFF;
    localparam logic [15:0] TOPPLE_LIMIT  = 16'd4;
    localparam logic [15:0] CENTRE_GRAINS = 16'd2000;

endpackage

`default_nettype wire

FILE: src/sps_grid_ram.sv
// ----------------------------------------------------------------------------
// Sandpile grid memory
// Simple dual-port RAM of 16-bit grain counts: one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_grid_ram #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered output.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/sandpile_toppling_sweep.sv
// ----------------------------------------------------------------------------
// Sandpile toppling sweep
// Holds a ROWS by COLS grid of grain counts in a RAM and runs in-place raster
// toppling sweeps on tick transactions; also takes cell writes and reads.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  s_       in         s_tvalid / s_tready     tdata: row, column, grains
//                                              tuser: operation
//  m_       out        m_tvalid / m_tready     tdata: cell_value, sweep_total
//                                              tuser: converged, swept
//  cfg_     in         cfg_valid / cfg_ready   cfg_data: ticks_per_sweep
//
// One transaction is in work at a time. A tick without a sweep, a write or an
// unused operation is answered from idle; a read passes through ST_READ for the
// registered RAM data. A sweep checks each cell in raster order and bumps the
// neighbors of a toppling cell one at a time through the single RAM port pair.
// After reset a clearing pass writes all ROWS*COLS cells, one per cycle,
// before s_tready rises; configuration writes are taken at any time.
// A stalled result holds the block until m_tready takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sandpile_toppling_sweep #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // row[5:0], column[11:6], grains[27:12], zero pad
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // cell_value[15:0], sweep_total[31:16]
    output logic      [1:0]  m_tuser,   // converged[0], swept[1]
    // Configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    localparam logic [AW-1:0] CENTRE_ADDR = AW'((ROWS / 2) * COLS + COLS / 2);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A      = AW'(COLS);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLS - 1);

    localparam int NB_RIGHT_I = int'(sps_pkg::NB_RIGHT);
    localparam int NB_LEFT_I  = int'(sps_pkg::NB_LEFT);
    localparam int NB_UP_I    = int'(sps_pkg::NB_UP);
    localparam int NB_DOWN_I  = int'(sps_pkg::NB_DOWN);

    // Lowest set bit of a neighbor mask.
    function automatic logic [1:0] low_idx(input logic [3:0] mask);
        logic [1:0] idx;
        if (mask[NB_RIGHT_I]) begin
            idx = sps_pkg::NB_RIGHT;
        end else if (mask[NB_LEFT_I]) begin
            idx = sps_pkg::NB_LEFT;
        end else if (mask[NB_UP_I]) begin
            idx = sps_pkg::NB_UP;
        end else begin
            idx = sps_pkg::NB_DOWN;
        end
        return idx;
    endfunction

    // Address of a neighbor of cell k.
    function automatic logic [AW-1:0] nb_addr(input logic [1:0] idx, input logic [AW-1:0] k);
        logic [AW-1:0] a;
        case (idx)
            sps_pkg::NB_RIGHT: a = k + AW'(1);
            sps_pkg::NB_LEFT:  a = k - AW'(1);
            sps_pkg::NB_UP:    a = k - COLS_A;
            sps_pkg::NB_DOWN:  a = k + COLS_A;
            default:           a = k;
        endcase
        return a;
    endfunction

    // Input field unpacking.
    logic [5:0]        in_row;
    logic [5:0]        in_col;
    logic [15:0]       in_grains;
    sps_pkg::sps_op_t  in_op;
    logic              in_inside;
    logic [AW-1:0]     in_addr;

    assign in_row    = s_tdata[5:0];
    assign in_col    = s_tdata[11:6];
    assign in_grains = s_tdata[27:12];
    assign in_op     = sps_pkg::sps_op_t'(s_tuser);
    assign in_inside = ({26'd0, in_row} < 32'(ROWS)) && ({26'd0, in_col} < 32'(COLS));
    assign in_addr   = AW'(({26'd0, in_row} * 32'(COLS)) + {26'd0, in_col});

    // Registers.
    sps_pkg::sps_state_t state_reg, state_next;
    logic [AW-1:0]  k_reg, k_next;
    logic [RW-1:0]  r_reg, r_next;
    logic [CW-1:0]  c_reg, c_next;
    logic [3:0]     nb_mask_reg, nb_mask_next;
    logic           toppled_reg, toppled_next;
    logic [15:0]    tick_count_reg, tick_count_next;
    logic           stable_reg, stable_next;
    logic [15:0]    sweep_count_reg, sweep_count_next;
    logic [15:0]    tps_reg;
    logic           m_valid_reg, m_valid_next;
    logic [15:0]    m_cell_reg, m_cell_next;
    logic           m_conv_reg, m_conv_next;
    logic           m_swept_reg, m_swept_next;
    logic [15:0]    m_total_reg, m_total_next;

    // RAM port signals.
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [15:0]    mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic [15:0]    mem_rdata;

    sps_grid_ram #(
        .DEPTH (CELLS)
    ) u_grid (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Handshakes.
    logic s_accept;
    assign s_tready  = (state_reg == sps_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_total_reg, m_cell_reg};
    assign m_tuser  = {m_swept_reg, m_conv_reg};

    // Helpers for the sweep.
    logic [15:0] tick_inc;
    logic [15:0] grain_inc;
    logic [3:0]  edge_mask;
    logic [1:0]  cur_idx;
    logic [3:0]  rest_mask;
    logic        last_cell;

    assign tick_inc  = (tick_count_reg == sps_pkg::GRAIN_MAX) ? tick_count_reg
                                                              : tick_count_reg + 16'd1;
    assign grain_inc = (mem_rdata == sps_pkg::GRAIN_MAX) ? mem_rdata : mem_rdata + 16'd1;
    assign last_cell = (k_reg == LAST_ADDR);
    assign cur_idx   = low_idx(nb_mask_reg);
    assign rest_mask = nb_mask_reg & ~(4'b0001 << cur_idx);

    always_comb begin
        edge_mask             = 4'b0000;
        edge_mask[NB_RIGHT_I] = (c_reg != LAST_COL);
        edge_mask[NB_LEFT_I]  = (c_reg != '0);
        edge_mask[NB_UP_I]    = (r_reg != '0);
        edge_mask[NB_DOWN_I]  = (r_reg != LAST_ROW);
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= 16'd1;
        end else if (cfg_valid && cfg_ready) begin
            tps_reg <= cfg_data;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sps_pkg::ST_CLEAR;
            k_reg           <= '0;
            r_reg           <= '0;
            c_reg           <= '0;
            nb_mask_reg     <= '0;
            toppled_reg     <= 1'b0;
            tick_count_reg  <= '0;
            stable_reg      <= 1'b0;
            sweep_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            r_reg           <= r_next;
            c_reg           <= c_next;
            nb_mask_reg     <= nb_mask_next;
            toppled_reg     <= toppled_next;
            tick_count_reg  <= tick_count_next;
            stable_reg      <= stable_next;
            sweep_count_reg <= sweep_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        m_cell_reg  <= m_cell_next;
        m_conv_reg  <= m_conv_next;
        m_swept_reg <= m_swept_next;
        m_total_reg <= m_total_next;
    end

    // Next state, RAM control and result loading.
    always_comb begin
        state_next       = state_reg;
        k_next           = k_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        nb_mask_next     = nb_mask_reg;
        toppled_next     = toppled_reg;
        tick_count_next  = tick_count_reg;
        stable_next      = stable_reg;
        sweep_count_next = sweep_count_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_cell_next      = m_cell_reg;
        m_conv_next      = m_conv_reg;
        m_swept_next     = m_swept_reg;
        m_total_next     = m_total_reg;
        mem_we           = 1'b0;
        mem_waddr        = k_reg;
        mem_wdata        = 16'd0;
        mem_re           = 1'b0;
        mem_raddr        = k_reg;

        case (state_reg)
            // Clearing pass after reset: zero, except the centre cell.
            sps_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                mem_wdata = (k_reg == CENTRE_ADDR) ? sps_pkg::CENTRE_GRAINS : 16'd0;
                if (last_cell) begin
                    k_next     = '0;
                    state_next = sps_pkg::ST_IDLE;
                end else begin
                    k_next = k_reg + AW'(1);
                end
            end

            // Take a transaction; simple cases produce their result at once.
            sps_pkg::ST_IDLE: begin
                if (s_accept) begin
                    m_cell_next  = 16'd0;
                    m_conv_next  = stable_reg;
                    m_swept_next = 1'b0;
                    m_total_next = sweep_count_reg;
                    case (in_op)
                        sps_pkg::OP_TICK: begin
                            if (tick_inc >= tps_reg) begin
                                tick_count_next = '0;
                                if (!stable_reg) begin
                                    sweep_count_next = (sweep_count_reg == sps_pkg::GRAIN_MAX)
                                                     ? sweep_count_reg
                                                     : sweep_count_reg + 16'd1;
                                    k_next       = '0;
                                    r_next       = '0;
                                    c_next       = '0;
                                    toppled_next = 1'b0;
                                    state_next   = sps_pkg::ST_SWEEP_RD;
                                end else begin
                                    m_valid_next = 1'b1;
                                end
                            end else begin
                                tick_count_next = tick_inc;
                                m_valid_next    = 1'b1;
                            end
                        end
                        sps_pkg::OP_WRITE: begin
                            if (in_inside) begin
                                mem_we      = 1'b1;
                                mem_waddr   = in_addr;
                                mem_wdata   = in_grains;
                                stable_next = 1'b0;
                                m_conv_next = 1'b0;
                            end
                            m_valid_next = 1'b1;
                        end
                        sps_pkg::OP_READ: begin
                            if (in_inside) begin
                                mem_re     = 1'b1;
                                mem_raddr  = in_addr;
                                state_next = sps_pkg::ST_READ;
                            end else begin
                                m_valid_next = 1'b1;
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // Read data arrives in the cycle after the request.
            sps_pkg::ST_READ: begin
                m_cell_next  = mem_rdata;
                m_valid_next = 1'b1;
                state_next   = sps_pkg::ST_IDLE;
            end

            // Request the current cell.
            sps_pkg::ST_SWEEP_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = k_reg;
                state_next = sps_pkg::ST_SWEEP_CHK;
            end

            // Examine the current cell; stable cells stream one per cycle.
            sps_pkg::ST_SWEEP_CHK: begin
                if (mem_rdata >= sps_pkg::TOPPLE_LIMIT) begin
                    mem_we       = 1'b1;
                    mem_waddr    = k_reg;
                    mem_wdata    = mem_rdata - sps_pkg::TOPPLE_LIMIT;
                    toppled_next = 1'b1;
                    nb_mask_next = edge_mask;
                    mem_re       = 1'b1;
                    mem_raddr    = nb_addr(low_idx(edge_mask), k_reg);
                    state_next   = sps_pkg::ST_SWEEP_NB;
                end else if (last_cell) begin
                    state_next = sps_pkg::ST_SWEEP_DONE;
                end else begin
                    k_next    = k_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = k_reg + AW'(1);
                    if (c_reg == LAST_COL) begin
                        c_next = '0;
                        r_next = r_reg + RW'(1);
                    end else begin
                        c_next = c_reg + CW'(1);
                    end
                end
            end

            // Bump one neighbor per cycle while fetching the next one.
            sps_pkg::ST_SWEEP_NB: begin
                mem_we       = 1'b1;
                mem_waddr    = nb_addr(cur_idx, k_reg);
                mem_wdata    = grain_inc;
                nb_mask_next = rest_mask;
                if (rest_mask != 4'b0000) begin
                    mem_re    = 1'b1;
                    mem_raddr = nb_addr(low_idx(rest_mask), k_reg);
                end else if (last_cell) begin
                    state_next = sps_pkg::ST_SWEEP_DONE;
                end else begin
                    k_next     = k_reg + AW'(1);
                    state_next = sps_pkg::ST_SWEEP_RD;
                    if (c_reg == LAST_COL) begin
                        c_next = '0;
                        r_next = r_reg + RW'(1);
                    end else begin
                        c_next = c_reg + CW'(1);
                    end
                end
            end

            // Sweep finished: update the converged flag and report.
            sps_pkg::ST_SWEEP_DONE: begin
                stable_next  = !toppled_reg;
                m_cell_next  = 16'd0;
                m_conv_next  = !toppled_reg;
                m_swept_next = 1'b1;
                m_total_next = sweep_count_reg;
                m_valid_next = 1'b1;
                state_next   = sps_pkg::ST_IDLE;
            end

            default: begin
                state_next = sps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sim/sandpile_sweep_checker.sv
// ----------------------------------------------------------------------------
// Sandpile sweep checker
// Watches the input, result and configuration channels of the sandpile
// toppling sweep block. It keeps its own copy of the grain grid, the tick and
// sweep counters and the sweep period. From every accepted input transaction
// it works out the result, and it compares each accepted result, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module sandpile_sweep_checker #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // row[5:0], column[11:6], grains[27:12], zero pad
    input  logic [1:0]  s_tuser,    // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // cell_value[15:0], sweep_total[31:16]
    input  logic [1:0]  m_tuser,    // converged[0], swept[1]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          results_pending
);

    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam int          MAX_REPORTS = 200;

    typedef struct packed {
        logic [15:0] cell_value;
        logic        converged;
        logic        swept;
        logic [15:0] sweep_total;
    } sweep_result_t;

    // Shadow state of the block.
    logic [15:0]   grain_grid [ROWS*COLS];
    logic [15:0]   tick_count;
    logic [15:0]   sweep_count;
    logic [15:0]   sweep_period;
    logic          grid_stable;

    sweep_result_t predicted_results [$];
    sweep_result_t observed;
    sweep_result_t predicted;
    int            results_seen;
    int            k;

    // A grain landing on a full cell is lost.
    function automatic void add_grain(input int idx);
        if (grain_grid[idx] != COUNT_MAX) begin
            grain_grid[idx] = grain_grid[idx] + 16'd1;
        end
    endfunction

    // Applies one input transaction to the shadow state and returns its result.
    function automatic sweep_result_t step_grid(input sps_pkg::sps_op_t op,
                                                input logic [5:0] row,
                                                input logic [5:0] col,
                                                input logic [15:0] grains);
        sweep_result_t res;
        int            idx;
        int            r;
        int            c;
        logic          toppled;
        logic          in_grid;
        res     = '0;
        in_grid = (int'(row) < ROWS) && (int'(col) < COLS);
        idx     = int'(row) * COLS + int'(col);
        case (op)
            sps_pkg::OP_TICK: begin
                if (tick_count != COUNT_MAX) begin
                    tick_count = tick_count + 16'd1;
                end
                if (tick_count >= sweep_period) begin
                    tick_count = '0;
                    if (!grid_stable) begin
                        if (sweep_count != COUNT_MAX) begin
                            sweep_count = sweep_count + 16'd1;
                        end
                        // In-place raster sweep: later cells see earlier topples.
                        toppled = 1'b0;
                        for (r = 0; r < ROWS; r++) begin
                            for (c = 0; c < COLS; c++) begin
                                if (grain_grid[r*COLS + c] >= sps_pkg::TOPPLE_LIMIT) begin
                                    toppled = 1'b1;
                                    grain_grid[r*COLS + c] = grain_grid[r*COLS + c]
                                                             - sps_pkg::TOPPLE_LIMIT;
                                    if (c > 0)        add_grain(r*COLS + c - 1);
                                    if (c + 1 < COLS) add_grain(r*COLS + c + 1);
                                    if (r > 0)        add_grain((r - 1)*COLS + c);
                                    if (r + 1 < ROWS) add_grain((r + 1)*COLS + c);
                                end
                            end
                        end
                        grid_stable = !toppled;
                        res.swept   = 1'b1;
                    end
                end
            end
            sps_pkg::OP_WRITE: begin
                if (in_grid) begin
                    grain_grid[idx] = grains;
                    grid_stable     = 1'b0;
                end
            end
            sps_pkg::OP_READ: begin
                if (in_grid) begin
                    res.cell_value = grain_grid[idx];
                end
            end
            default: begin
            end
        endcase
        res.converged   = grid_stable;
        res.sweep_total = sweep_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result %0d: %s is %0d, predicted %0d",
                     $realtime, results_seen, what, got, want);
        end
    endtask

    // Predict on every input transaction, compare on every result transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (k = 0; k < ROWS*COLS; k++) begin
                grain_grid[k] = '0;
            end
            grain_grid[(ROWS/2)*COLS + COLS/2] = sps_pkg::CENTRE_GRAINS;
            tick_count   = '0;
            sweep_count  = '0;
            sweep_period = 16'd1;
            grid_stable  = 1'b0;
            predicted_results.delete();
            results_seen   = 0;
            mismatch_count = 0;
        end else begin
            // The bench must keep period changes to times when nothing is in flight; the checker does not enforce this.
            if (cfg_valid && cfg_ready) begin
                sweep_period = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                predicted_results.push_back(step_grid(sps_pkg::sps_op_t'(s_tuser),
                                                      s_tdata[5:0], s_tdata[11:6],
                                                      s_tdata[27:12]));
            end
            if (m_tvalid && m_tready) begin
                observed.cell_value  = m_tdata[15:0];
                observed.sweep_total = m_tdata[31:16];
                observed.converged   = m_tuser[0];
                observed.swept       = m_tuser[1];
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected result, tdata", int'(m_tdata), 0);
                end else begin
                    predicted = predicted_results.pop_front();
                    if (observed.cell_value !== predicted.cell_value) begin
                        report_mismatch("cell_value", observed.cell_value,
                                        predicted.cell_value);
                    end
                    if (observed.converged !== predicted.converged) begin
                        report_mismatch("converged", observed.converged,
                                        predicted.converged);
                    end
                    if (observed.swept !== predicted.swept) begin
                        report_mismatch("swept", observed.swept, predicted.swept);
                    end
                    if (observed.sweep_total !== predicted.sweep_total) begin
                        report_mismatch("sweep_total", observed.sweep_total,
                                        predicted.sweep_total);
                    end
                end
                results_seen++;
            end
        end
        results_pending = predicted_results.size();
    end

endmodule

FILE: sim/sandpile_toppling_sweep_test.sv
// ----------------------------------------------------------------------------
// Sandpile toppling sweep testbench
// Drives tick, write and read transactions into the sandpile block: first a
// directed sequence (saturation, border loss, convergence, period changes),
// then random traffic in four phases, each setting its sweep period and idling.
// A checker beside the block predicts and compares every result; this top
// only makes stimulus, watches for a hang and gives the verdict.
// ----------------------------------------------------------------------------

module sandpile_toppling_sweep_test;

    localparam int ROWS           = 64;
    localparam int COLS           = 64;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int LONG_HOLD      = 300;
    // Worst sweep topples every cell; this limit is many such sweeps over.
    localparam int QUIET_LIMIT    = 200000;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    int          mismatches;
    int          results_pending;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_request   = 1'b0;
    int          quiet_cycles   = 0;
    int          phase;
    int          n;

    sandpile_toppling_sweep #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sandpile_sweep_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatches),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offers one transaction, after an optional random gap, and waits for it
    // to be taken. The valid stays high so back-to-back items need no bubble.
    task automatic push_item(input sps_pkg::sps_op_t op, input logic [5:0] row,
                             input logic [5:0] col, input logic [15:0] grains);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, grains, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // Writes the sweep period while the block is idle.
    task automatic set_period(input logic [15:0] period);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= period;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: most cell accesses land in a window around the centre so
    // writes, topples and reads interact; a few large piles stress spreading.
    task automatic push_random_item();
        int                pick;
        sps_pkg::sps_op_t  op;
        logic [5:0]        row;
        logic [5:0]        col;
        logic [15:0]       grains;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            op = sps_pkg::OP_TICK;
        end else if (pick < 65) begin
            op = sps_pkg::OP_WRITE;
        end else if (pick < 95) begin
            op = sps_pkg::OP_READ;
        end else begin
            op = sps_pkg::OP_NONE;
        end
        if ($urandom_range(0, 99) < 65) begin
            row = 6'($urandom_range(28, 36));
            col = 6'($urandom_range(28, 36));
        end else begin
            row = 6'($urandom);
            col = 6'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (op != sps_pkg::OP_WRITE || pick >= 95) begin
            grains = 16'($urandom);
        end else if (pick < 75) begin
            grains = 16'($urandom_range(0, 12));
        end else begin
            grains = 16'($urandom_range(0, 255));
        end
        push_item(op, row, col, grains);
    endtask

    // Result side: random stalls, and on request one long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Hang detection: too long without any transaction on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset contents: the centre pile and empty corners.
        push_item(sps_pkg::OP_READ, 6'd32, 6'd32, 16'h0000);
        push_item(sps_pkg::OP_READ, 6'd0, 6'd0, 16'hFFFF);
        push_item(sps_pkg::OP_READ, 6'd63, 6'd63, 16'h0000);

        // Shrink the centre pile; corner cell loses grains over the border;
        // a full cell takes a grain from its neighbor and keeps 65535.
        push_item(sps_pkg::OP_WRITE, 6'd32, 6'd32, 16'd9);
        push_item(sps_pkg::OP_WRITE, 6'd0, 6'd0, 16'd4);
        push_item(sps_pkg::OP_WRITE, 6'd0, 6'd62, 16'd4);
        push_item(sps_pkg::OP_WRITE, 6'd0, 6'd63, 16'hFFFF);
        push_item(sps_pkg::OP_WRITE, 6'd63, 6'd0, 16'd5);
        push_item(sps_pkg::OP_TICK, 6'd0, 6'd0, 16'h0000);
        push_item(sps_pkg::OP_READ, 6'd0, 6'd63, 16'h0000);
        push_item(sps_pkg::OP_READ, 6'd0, 6'd62, 16'h0000);
        push_item(sps_pkg::OP_WRITE, 6'd0, 6'd63, 16'h0000);

        // Alternating bit patterns on every field, then clear both cells again.
        push_item(sps_pkg::OP_WRITE, 6'd42, 6'd21, 16'hA5A5);
        push_item(sps_pkg::OP_READ, 6'd42, 6'd21, 16'h5A5A);
        push_item(sps_pkg::OP_WRITE, 6'd21, 6'd42, 16'h5A5A);
        push_item(sps_pkg::OP_READ, 6'd21, 6'd42, 16'hA5A5);
        push_item(sps_pkg::OP_WRITE, 6'd42, 6'd21, 16'h0000);
        push_item(sps_pkg::OP_WRITE, 6'd21, 6'd42, 16'h0000);

        // Sweep until the grid settles; later ticks find it converged.
        repeat (7) push_item(sps_pkg::OP_TICK, 6'd63, 6'd63, 16'hFFFF);
        push_item(sps_pkg::OP_NONE, 6'd63, 6'd63, 16'hFFFF);
        push_item(sps_pkg::OP_READ, 6'd32, 6'd32, 16'h0000);

        // Longest period: ticks only count. Then lower the period below the
        // tick count so the very next tick sweeps.
        set_period(16'hFFFF);
        push_item(sps_pkg::OP_WRITE, 6'd32, 6'd32, 16'd4);
        repeat (4) push_item(sps_pkg::OP_TICK, 6'd0, 6'd0, 16'h0000);
        set_period(16'd2);
        push_item(sps_pkg::OP_TICK, 6'd0, 6'd0, 16'h0000);
        push_item(sps_pkg::OP_READ, 6'd32, 6'd33, 16'h0000);

        // Random traffic in four phases, each setting its period and idle rates.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    set_period(16'd1);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    set_period(16'd0);
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2: begin
                    set_period(16'($urandom_range(2, 4)));
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default: begin
                    set_period(16'd1);
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Back-pressure fills the block while the sender keeps offering.
                if (phase == 0 && n == 10) begin
                    hold_request = 1'b1;
                end
                // Pause mid-phase until everything has come back.
                if (phase == 1 && n == 14) begin
                    drain_results();
                end
                push_random_item();
            end
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && results_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/sps_pkg.sv
src/sps_grid_ram.sv
src/sandpile_toppling_sweep.sv
sim/sandpile_sweep_checker.sv
sim/sandpile_toppling_sweep_test.sv
